### rtl/core/dwr_pkg.sv
// Shared constants and types of the dotted waveform rasterizer.
package dwr_pkg;

  localparam int MAX_DOTS = 64;
  localparam int MAX_DIM  = 1024;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // Divider: remainder width and width of the low dividend bits shifted in
  localparam int DIV_RW = 36;
  localparam int DIV_LW = 28;
  localparam int DIV_CW = 5;

  // Square root: radicand and root widths
  localparam int SQ_DW = 38;
  localparam int SQ_RW = 35;
  localparam int SQ_SW = 40;
  localparam int SQ_CW = 6;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_X_RANGE_LOW  = 3'd2,
    REG_X_RANGE_HIGH = 3'd3,
    REG_Y_RANGE_LOW  = 3'd4,
    REG_Y_RANGE_HIGH = 3'd5,
    REG_DOT_STEP     = 3'd6,
    REG_SAMPLES      = 3'd7
  } cfg_idx_t;

endpackage

### rtl/core/dotted_waveform_rasterizer.sv
// Top level: sequencer, shared multiplier, config registers and dot output.
//
//   channel | direction | handshake          | payload
//   in_     | slave     | in_tvalid/tready   | tdata sample/unit, tuser first_of_spike
//   out_    | master    | out_tvalid/tready  | tdata x/y/color, tlast, tuser truncated
//   cfg_    | write     | cfg_we             | cfg_addr, cfg_wdata
//
// One sample runs the two coordinate divisions plus, on a segment, the
// products and the square root, one division per dot on the shared divider,
// plus one remainder pass; the divider sets the pace.
// in_tready is high only while the sequencer is idle. A full output register
// holds the sequencer at the next dot. Reset restores register defaults and
// clears phase, previous point and sample index.
module dotted_waveform_rasterizer
  import dwr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // sample_value[15:0], unit_id[23:16]
  input  logic              in_tuser,   // first_of_spike
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // pixel_x[9:0], pixel_y[19:10], color_index[27:20]
  output logic              out_tlast,  // last_dot
  output logic              out_tuser,  // truncated
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_MX, S_DX, S_DXW, S_MY, S_DY, S_DYW, S_DD, S_SQ1, S_SQ2, S_SQ3,
    S_D0, S_SQW, S_FL, S_C, S_LOOP, S_FW, S_PX, S_PY, S_PE, S_KADV, S_MODW,
    S_END, S_EMIT, S_FIN
  } state_t;

  state_t state_r, ret_r;

  // configuration
  logic [10:0] width_r, height_r, xhi_r, step_r, spc_r;
  logic signed [10:0] xlo_r;
  logic signed [15:0] ylo_r, yhi_r;

  // carried state
  logic [15:0]        phase_r;
  logic signed [11:0] prev_col_r;
  logic signed [17:0] prev_row_r;
  logic [10:0]        sidx_r;

  // item work registers
  logic signed [15:0] v_r;
  logic [7:0]         unit_r;
  logic               start_r;
  logic [10:0]        idx_r;
  logic signed [11:0] col_r;
  logic signed [17:0] row_r;
  logic signed [12:0] dx_r;
  logic signed [18:0] dy_r;
  logic [37:0]        d_r;
  logic [34:0]        r16_r;
  logic [19:0]        c_r;
  logic [20:0]        k_r;
  logic [17:0]        f_r;
  logic               neg_r;
  logic signed [25:0] cx_r, cy_r;
  logic [6:0]         count_r;
  logic               dropped_r;
  logic               pend_v_r;
  logic [9:0]         pend_x_r, pend_y_r;

  // output register
  logic        out_v_r;
  logic [9:0]  out_x_r, out_y_r;
  logic [7:0]  out_c_r;
  logic        out_last_r, out_trunc_r;

  // shared multiplier
  logic signed [19:0] mul_a, mul_b;
  logic signed [39:0] mul_p_r;

  // shared divider and root unit
  logic              div_go_r, sq_go_r;
  logic [DIV_RW-1:0] div_rem0_r, div_dvs_r;
  logic [DIV_LW-1:0] div_lo_r;
  logic [DIV_CW-1:0] div_nb_r;
  logic              div_done, sq_done;
  logic [DIV_LW-1:0] div_quo;
  logic [DIV_RW-1:0] div_rem;
  logic [SQ_RW-1:0]  sq_root;

  logic [10:0]        step_eff, spc_eff, wlim, hlim;
  logic signed [12:0] xnum, xden;
  logic signed [16:0] ynum, yden;
  logic [39:0]        pmag;
  logic [28:0]        qv;
  logic signed [24:0] rnd;
  logic [18:0]        fl;
  logic               out_free;
  logic               in_box;

  assign step_eff = (step_r == 11'd0) ? 11'd1 : step_r;
  assign spc_eff  = (spc_r == 11'd0) ? 11'd1 : spc_r;
  assign wlim     = (width_r < 11'(MAX_DIM)) ? width_r : 11'(MAX_DIM);
  assign hlim     = (height_r < 11'(MAX_DIM)) ? height_r : 11'(MAX_DIM);
  assign xnum     = $signed({2'b00, idx_r}) - 13'(xlo_r);
  assign xden     = $signed({2'b00, xhi_r}) - 13'(xlo_r);
  assign ynum     = 17'(v_r) - 17'(ylo_r);
  assign yden     = 17'(yhi_r) - 17'(ylo_r);
  assign pmag     = mul_p_r[39] ? 40'(-mul_p_r) : 40'(mul_p_r);
  assign qv       = {1'b0, div_quo};
  assign fl       = r16_r[34:16];
  assign out_free = !out_v_r || out_tready;
  assign in_box   = !cx_r[25] && (cx_r < $signed({15'd0, wlim})) &&
                    !cy_r[25] && (cy_r < $signed({15'd0, hlim}));

  // arithmetic shift of (p + 0.5) by 16 is the rounding of the reference
  logic signed [40:0] rsum;
  assign rsum = 41'(mul_p_r) + 41'sd32768;
  assign rnd  = rsum[40:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MX:  begin mul_a = 20'(xnum); mul_b = $signed({9'd0, width_r}); end
      S_MY:  begin mul_a = 20'(ynum); mul_b = $signed({9'd0, height_r}); end
      S_SQ1: begin mul_a = 20'(dx_r); mul_b = 20'(dx_r); end
      S_SQ2: begin mul_a = 20'(dy_r); mul_b = 20'(dy_r); end
      S_FL:  begin mul_a = $signed({1'b0, fl}); mul_b = $signed({1'b0, fl}); end
      S_PX:  begin mul_a = 20'(dx_r); mul_b = $signed({2'b00, f_r}); end
      S_PY:  begin mul_a = 20'(dy_r); mul_b = $signed({2'b00, f_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  dwr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go_r),
    .rem0    (div_rem0_r),
    .lo      (div_lo_r),
    .nbits   (div_nb_r),
    .divisor (div_dvs_r),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  dwr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go_r),
    .radicand (d_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd256;
      height_r   <= 11'd256;
      xlo_r      <= -11'sd1;
      xhi_r      <= 11'd64;
      ylo_r      <= -16'sd1024;
      yhi_r      <= 16'sd1024;
      step_r     <= 11'd10;
      spc_r      <= 11'd64;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[10:0];
        REG_X_RANGE_LOW:  xlo_r    <= $signed(cfg_wdata[10:0]);
        REG_X_RANGE_HIGH: xhi_r    <= cfg_wdata[10:0];
        REG_Y_RANGE_LOW:  ylo_r    <= $signed(cfg_wdata);
        REG_Y_RANGE_HIGH: yhi_r    <= $signed(cfg_wdata);
        REG_DOT_STEP:     step_r   <= cfg_wdata[10:0];
        REG_SAMPLES:      spc_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_FIN;
      phase_r    <= '0;
      prev_col_r <= '0;
      prev_row_r <= '0;
      sidx_r     <= '0;
      out_v_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      div_go_r   <= 1'b0;
      sq_go_r    <= 1'b0;
      count_r    <= '0;
      dropped_r  <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      sq_go_r  <= 1'b0;
      if (out_v_r && out_tready) out_v_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            v_r       <= $signed(in_tdata[15:0]);
            unit_r    <= in_tdata[23:16];
            start_r   <= in_tuser || (sidx_r == 11'd0) || (sidx_r >= spc_eff);
            idx_r     <= (in_tuser || (sidx_r == 11'd0) || (sidx_r >= spc_eff)) ?
                         11'd0 : sidx_r;
            k_r       <= {5'd0, phase_r};
            count_r   <= '0;
            dropped_r <= 1'b0;
            state_r   <= S_MX;
          end
        end
        S_MX: state_r <= S_DX;
        S_DX: begin
          if (xden == 13'sd0) begin
            col_r   <= '0;
            state_r <= S_MY;
          end else begin
            div_go_r   <= 1'b1;
            div_rem0_r <= '0;
            div_lo_r   <= pmag[DIV_LW-1:0];
            div_nb_r   <= DIV_CW'(DIV_LW);
            div_dvs_r  <= DIV_RW'(xden[12] ? 13'(-xden) : xden);
            neg_r      <= mul_p_r[39] ^ xden[12];
            state_r    <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_done) begin
            if (neg_r) col_r <= (qv > 29'd2048) ? -12'sd2048 : 12'(-qv[11:0]);
            else       col_r <= (qv > 29'd2047) ? 12'sd2047 : $signed(qv[11:0]);
            state_r <= S_MY;
          end
        end
        S_MY: state_r <= S_DY;
        S_DY: begin
          if (yden == 17'sd0) begin
            row_r   <= '0;
            state_r <= S_DD;
          end else begin
            div_go_r   <= 1'b1;
            div_rem0_r <= '0;
            div_lo_r   <= pmag[DIV_LW-1:0];
            div_nb_r   <= DIV_CW'(DIV_LW);
            div_dvs_r  <= DIV_RW'(yden[16] ? 17'(-yden) : yden);
            neg_r      <= mul_p_r[39] ^ yden[16];
            state_r    <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_done) begin
            if (neg_r) row_r <= (qv > 29'd131072) ? -18'sd131072 : 18'(-qv[17:0]);
            else       row_r <= (qv > 29'd131071) ? 18'sd131071 : $signed(qv[17:0]);
            state_r <= S_DD;
          end
        end
        S_DD: begin
          dx_r    <= 13'(col_r) - 13'(prev_col_r);
          dy_r    <= 19'(row_r) - 19'(prev_row_r);
          state_r <= start_r ? S_END : S_SQ1;
        end
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: begin
          d_r     <= mul_p_r[37:0];
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          d_r     <= d_r + mul_p_r[37:0];
          state_r <= S_D0;
        end
        S_D0: begin
          if (d_r == 38'd0) begin
            state_r <= S_END;
          end else begin
            sq_go_r <= 1'b1;
            state_r <= S_SQW;
          end
        end
        S_SQW: begin
          if (sq_done) begin
            r16_r   <= sq_root;
            state_r <= S_FL;
          end
        end
        S_FL: state_r <= S_C;
        S_C: begin
          c_r     <= (mul_p_r[37:0] == d_r) ? {1'b0, fl} : {1'b0, fl} + 20'd1;
          state_r <= S_LOOP;
        end
        S_LOOP: begin
          div_go_r <= 1'b1;
          if (k_r < {1'b0, c_r}) begin
            // fraction k / r in 16.16, quotient fits 18 bits since k < r
            div_rem0_r <= {1'b0, k_r, 14'd0};
            div_lo_r   <= '0;
            div_nb_r   <= DIV_CW'(18);
            div_dvs_r  <= {1'b0, r16_r};
            state_r    <= S_FW;
          end else begin
            div_rem0_r <= '0;
            div_lo_r   <= {k_r[19:0], 8'd0};
            div_nb_r   <= DIV_CW'(20);
            div_dvs_r  <= {16'd0, c_r};
            state_r    <= S_MODW;
          end
        end
        S_FW: begin
          if (div_done) begin
            f_r     <= div_quo[17:0];
            state_r <= S_PX;
          end
        end
        S_PX: state_r <= S_PY;
        S_PY: begin
          cx_r    <= 26'(prev_col_r) + 26'(rnd);
          state_r <= S_PE;
        end
        S_PE: begin
          cy_r    <= 26'(prev_row_r) + 26'(rnd);
          ret_r   <= S_KADV;
          state_r <= S_EMIT;
        end
        S_KADV: begin
          k_r     <= k_r + {10'd0, step_eff};
          state_r <= S_LOOP;
        end
        S_MODW: begin
          if (div_done) begin
            k_r     <= {1'b0, div_rem[19:0]};
            state_r <= S_END;
          end
        end
        S_END: begin
          if (k_r == 21'd0) begin
            cx_r    <= 26'(col_r);
            cy_r    <= 26'(row_r);
            k_r     <= {10'd0, step_eff};
            ret_r   <= S_FIN;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_EMIT: begin
          // hold one dot back so the final one can carry last and truncated
          if (!in_box) begin
            state_r <= ret_r;
          end else if (count_r >= 7'(MAX_DOTS)) begin
            dropped_r <= 1'b1;
            state_r   <= ret_r;
          end else if (!pend_v_r) begin
            pend_v_r <= 1'b1;
            pend_x_r <= cx_r[9:0];
            pend_y_r <= cy_r[9:0];
            count_r  <= count_r + 7'd1;
            state_r  <= ret_r;
          end else if (out_free) begin
            out_v_r     <= 1'b1;
            out_x_r     <= pend_x_r;
            out_y_r     <= pend_y_r;
            out_c_r     <= unit_r;
            out_last_r  <= 1'b0;
            out_trunc_r <= 1'b0;
            pend_x_r    <= cx_r[9:0];
            pend_y_r    <= cy_r[9:0];
            count_r     <= count_r + 7'd1;
            state_r     <= ret_r;
          end
        end
        S_FIN: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_r     <= 1'b1;
              out_x_r     <= pend_x_r;
              out_y_r     <= pend_y_r;
              out_c_r     <= unit_r;
              out_last_r  <= 1'b1;
              out_trunc_r <= dropped_r;
              pend_v_r    <= 1'b0;
            end
            phase_r    <= (k_r > 21'd65535) ? 16'hFFFF : k_r[15:0];
            prev_col_r <= col_r;
            prev_row_r <= row_r;
            sidx_r     <= idx_r + 11'd1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_c_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_trunc_r;

endmodule

### rtl/core/dwr_div.sv
// Restoring divider, one quotient bit per cycle, preset remainder allowed.
module dwr_div
  import dwr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_RW-1:0] rem0,
  input  logic [DIV_LW-1:0] lo,
  input  logic [DIV_CW-1:0] nbits,
  input  logic [DIV_RW-1:0] divisor,
  output logic              done,
  output logic [DIV_LW-1:0] quo,
  output logic [DIV_RW-1:0] rem
);

  logic [DIV_RW-1:0] rem_r;
  logic [DIV_LW-1:0] lo_r;
  logic [DIV_LW-1:0] quo_r;
  logic [DIV_RW-1:0] div_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_RW:0]   trial;
  logic [DIV_RW:0]   diff;

  assign trial = {rem_r, lo_r[DIV_LW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r  <= rem0;
        lo_r   <= lo;
        quo_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= diff[DIV_RW] ? trial[DIV_RW-1:0] : diff[DIV_RW-1:0];
        quo_r <= {quo_r[DIV_LW-2:0], ~diff[DIV_RW]};
        lo_r  <= {lo_r[DIV_LW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### rtl/core/dwr_sqrt.sv
// Bit-serial square root giving floor(sqrt(d * 2^32)), one root bit per cycle.
module dwr_sqrt
  import dwr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [SQ_DW-1:0] radicand,
  output logic             done,
  output logic [SQ_RW-1:0] root
);

  logic [SQ_DW-1:0] ds_r;
  logic [SQ_SW-1:0] rem_r;
  logic [SQ_RW-1:0] root_r;
  logic [SQ_CW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SQ_SW-1:0] remn;
  logic [SQ_SW-1:0] trial;

  assign remn  = {rem_r[SQ_SW-3:0], ds_r[SQ_DW-1:SQ_DW-2]};
  assign trial = {3'b000, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        ds_r   <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        // one step per root bit
        cnt_r  <= SQ_CW'(SQ_RW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        ds_r <= {ds_r[SQ_DW-3:0], 2'b00};
        if (remn >= trial) begin
          rem_r  <= remn - trial;
          root_r <= {root_r[SQ_RW-2:0], 1'b1};
        end else begin
          rem_r  <= remn;
          root_r <= {root_r[SQ_RW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SQ_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### dv/dwr_checker.sv
// Checker for the dotted waveform rasterizer: mirrors config, predicts dots, compares results.
module dwr_checker
  import dwr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,
  input  logic              out_tlast,
  input  logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                dots_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] color;
    logic       last;
    logic       trunc;
  } dot_t;

  dot_t dot_q[$];

  // Mirrored registers
  logic [10:0] img_w, img_h, xr_lo, xr_hi, step_r, spp_r;
  logic [15:0] yr_lo, yr_hi;

  // Mirrored state
  longint unsigned phase;
  longint          last_col, last_row;
  int unsigned     samp_idx;

  initial begin
    fail_count   = 0;
    dots_pending = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: dot mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint lin_map(input longint p, input longint lo, input longint hi,
                                     input longint pix);
    longint den;
    den = hi - lo;
    if (den == 0) return 0;
    return ((p - lo) * pix) / den;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(sqrt(d * 2^32)), bit by bit
  function automatic longint unsigned root16(input longint unsigned d);
    longint unsigned rem, root, pair, trial;
    rem  = 0;
    root = 0;
    for (int i = 0; i < 35; i++) begin
      pair  = (i < 19) ? ((d >> (36 - 2 * i)) & 3) : 0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint round16(input longint v);
    v = v + 32768;
    if (v >= 0) return v / 65536;
    return -((-v + 65535) / 65536);
  endfunction

  task automatic predict_dots(input logic [15:0] value, input logic [7:0] unit, input logic first);
    dot_t            dots[$];
    dot_t            d;
    longint unsigned spp, s, k, sq, r16, fl, c;
    longint          col, row, dx, dy, f, wlim, hlim, px, py;
    logic            start, dropped;
    int unsigned     idx;
    spp     = (spp_r == 0) ? 1 : spp_r;
    s       = (step_r == 0) ? 1 : step_r;
    start   = first || samp_idx == 0 || samp_idx >= spp;
    idx     = start ? 0 : samp_idx;
    k       = phase;
    dropped = 0;
    wlim    = (img_w < MAX_DIM) ? img_w : MAX_DIM;
    hlim    = (img_h < MAX_DIM) ? img_h : MAX_DIM;
    col = clip(lin_map(idx, longint'($signed(xr_lo)), longint'(xr_hi), longint'(img_w)),
               -2048, 2047);
    row = clip(lin_map(longint'($signed(value)), longint'($signed(yr_lo)),
                       longint'($signed(yr_hi)), longint'(img_h)), -131072, 131071);
    if (!start) begin
      dx = col - last_col;
      dy = row - last_row;
      sq = dx * dx + dy * dy;
      if (sq != 0) begin
        r16 = root16(sq);
        fl  = r16 >> 16;
        c   = (fl * fl == sq) ? fl : fl + 1;
        for (; k < c; k += s) begin
          f  = longint'((k << 32) / r16);
          px = last_col + round16(dx * f);
          py = last_row + round16(dy * f);
          if (px >= 0 && px < wlim && py >= 0 && py < hlim) begin
            if (dots.size() >= MAX_DOTS) begin
              dropped = 1;
            end else begin
              d = '{x: px[9:0], y: py[9:0], color: unit, last: 0, trunc: 0};
              dots.push_back(d);
            end
          end
        end
        k = k % c;
      end
    end
    if (k == 0) begin
      if (col >= 0 && col < wlim && row >= 0 && row < hlim) begin
        if (dots.size() >= MAX_DOTS) begin
          dropped = 1;
        end else begin
          d = '{x: col[9:0], y: row[9:0], color: unit, last: 0, trunc: 0};
          dots.push_back(d);
        end
      end
      k = k + s;
    end
    phase    = (k > 65535) ? 65535 : k;
    last_col = col;
    last_row = row;
    samp_idx = idx + 1;
    if (dots.size() > 0) begin
      dots[dots.size() - 1].last  = 1;
      dots[dots.size() - 1].trunc = dropped;
    end
    foreach (dots[i]) dot_q.push_back(dots[i]);
  endtask

  always @(posedge clk) begin
    dot_t want;
    if (!rst_n) begin
      img_w  = 256;
      img_h  = 256;
      xr_lo  = 11'h7FF;
      xr_hi  = 64;
      yr_lo  = 16'hFC00;
      yr_hi  = 1024;
      step_r = 10;
      spp_r  = 64;
      phase    = 0;
      last_col = 0;
      last_row = 0;
      samp_idx = 0;
      dot_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_IMAGE_WIDTH:  img_w  = cfg_wdata[10:0];
          REG_IMAGE_HEIGHT: img_h  = cfg_wdata[10:0];
          REG_X_RANGE_LOW:  xr_lo  = cfg_wdata[10:0];
          REG_X_RANGE_HIGH: xr_hi  = cfg_wdata[10:0];
          REG_Y_RANGE_LOW:  yr_lo  = cfg_wdata;
          REG_Y_RANGE_HIGH: yr_hi  = cfg_wdata;
          REG_DOT_STEP:     step_r = cfg_wdata[10:0];
          REG_SAMPLES:      spp_r  = cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_dots(in_tdata[15:0], in_tdata[23:16], in_tuser);
      if (out_tvalid && out_tready) begin
        if (dot_q.size() == 0) begin
          report("unexpected dot x", 32'(out_tdata[9:0]), 32'd0);
        end else begin
          want = dot_q.pop_front();
          if (out_tdata[9:0] !== want.x)
            report("pixel_x", 32'(out_tdata[9:0]), 32'(want.x));
          if (out_tdata[19:10] !== want.y)
            report("pixel_y", 32'(out_tdata[19:10]), 32'(want.y));
          if (out_tdata[27:20] !== want.color)
            report("color_index", 32'(out_tdata[27:20]), 32'(want.color));
          if (out_tlast !== want.last)
            report("last_dot", 32'(out_tlast), 32'(want.last));
          if (out_tuser !== want.trunc)
            report("truncated", 32'(out_tuser), 32'(want.trunc));
        end
      end
    end
    dots_pending = dot_q.size();
  end

endmodule

### dv/tb_dotted_waveform_rasterizer.sv
// Testbench top for the dotted waveform rasterizer: stimulus, config phases and verdict.
module tb_dotted_waveform_rasterizer;
  import dwr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 150000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic              in_tuser = 0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [31:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int                fail_count;
  int                dots_pending;
  int                idle_cycles = 0;
  logic              calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dotted_waveform_rasterizer DUT (.*);

  dwr_checker u_checker (.*);

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    if (calm || $urandom_range(3) != 0) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  // Receiver stalls
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 0;
        stall--;
      end else begin
        out_tready = 1;
        stall = gap_len();
      end
    end
  end

  task automatic send_sample(input logic [15:0] value, input logic [7:0] unit, input logic first);
    int gap;
    in_tvalid = 1;
    in_tdata  = {unit, value};
    in_tuser  = first;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold until every expected dot is out and the sequencer is idle
  task automatic drain();
    in_tvalid = 0;
    while (dots_pending != 0 || !in_tready) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    = 1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic setup(input int w, input int h, input int xl, input int xh, input int yl,
                       input int yh, input int stp, input int spp);
    drain();
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
    write_reg(REG_X_RANGE_LOW, 16'(xl));
    write_reg(REG_X_RANGE_HIGH, 16'(xh));
    write_reg(REG_Y_RANGE_LOW, 16'(yl));
    write_reg(REG_Y_RANGE_HIGH, 16'(yh));
    write_reg(REG_DOT_STEP, 16'(stp));
    write_reg(REG_SAMPLES, 16'(spp));
  endtask

  // Mostly well-formed spikes with random content; some stray start flags
  task automatic spikes(input int n, input int vmin, input int vmax, input int maxlen);
    int   len, sent, v;
    logic [7:0] unit;
    sent = 0;
    while (sent < n) begin
      len  = $urandom_range(maxlen, 1);
      unit = 8'($urandom_range(255));
      for (int j = 0; j < len && sent < n; j++) begin
        v = vmin + int'($urandom_range(vmax - vmin));
        if ($urandom_range(9) == 0)
          send_sample(16'(v), 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
          send_sample(16'(v), unit, j == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Reset defaults: amplitude extremes, unit extremes, mid-spike restart
    send_sample(16'sd0, 8'd0, 1'b0);
    send_sample(16'sd1000, 8'd255, 1'b0);
    send_sample(-16'sd1000, 8'd255, 1'b0);
    send_sample(16'sd32767, 8'd1, 1'b0);
    send_sample(-16'sd32768, 8'd2, 1'b0);
    send_sample(16'sd0, 8'd3, 1'b1);
    send_sample(16'sd500, 8'd3, 1'b0);
    send_sample(16'sd500, 8'd3, 1'b0);
    calm = 1;
    spikes(12, -1500, 1500, 70);
    calm = 0;

    // Degenerate image and inverted ranges, spike length zero
    setup(1, 1, 1023, 0, 32767, -32768, 1024, 0);
    send_sample(16'sd32767, 8'd255, 1'b0);
    send_sample(-16'sd32768, 8'd0, 1'b0);
    send_sample(16'sd0, 8'd7, 1'b1);

    // Equal range bounds: zero-length segments, step zero
    setup(64, 64, 5, 5, 100, 100, 0, 4);
    spikes(6, -32768, 32767, 4);

    // Largest image, full amplitude range: long segments overflow the dot limit
    setup(1024, 1024, -1, 1024, -32768, 32767, 16, 1024);
    send_sample(-16'sd32768, 8'd9, 1'b1);
    send_sample(16'sd32767, 8'd9, 1'b0);
    send_sample(-16'sd32768, 8'd9, 1'b0);
    spikes(50, -32768, 32767, 40);

    // Small image, samples running off both edges
    setup(200, 150, 0, 20, -500, 500, 3, 8);
    spikes(50, -800, 800, 12);

    // Large step, phase carried across segments
    setup(1024, 1000, -1, 1023, -32768, 32767, 1024, 1024);
    spikes(30, -32768, 32767, 30);

    setup(256, 256, -1, 64, -1024, 1024, 10, 64);
    spikes(8, -1500, 1500, 70);

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
